FILE: sv/csq_pkg.sv
// Shared types, codes and constants for the compass I2C read sequencer.
// Used by every module of the block; depends on nothing.
package csq_pkg;

    // Number of data bytes read from the compass (2 to 6).
    localparam int READ_BYTES_DEF = 6;
    localparam int BYTE_IDX_W     = 3;
    localparam int MEAS_W         = 48;

    localparam logic [6:0]  SLAVE_ADDRESS_RST = 7'd25;
    localparam logic [7:0]  COMMAND_BYTE_RST  = 8'h50;
    localparam logic [15:0] SETTLE_TICKS_RST  = 16'd10000;

    // I2C master status codes.
    localparam logic [7:0] ST_START_DONE = 8'h08;
    localparam logic [7:0] ST_ADDRW_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_ADDRR_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDRESS = 2'd0,
        CFG_COMMAND_BYTE  = 2'd1,
        CFG_SETTLE_TICKS  = 2'd2
    } cfg_index_t;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START1 = 8'b0000_0010,
        PH_ADDRW  = 8'b0000_0100,
        PH_CMD    = 8'b0000_1000,
        PH_SETTLE = 8'b0001_0000,
        PH_START2 = 8'b0010_0000,
        PH_ADDRR  = 8'b0100_0000,
        PH_READ   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic [7:0]  command_byte;
        logic [15:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  bus_action;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic        failed;
        logic [15:0] heading;
        logic [15:0] pitch;
        logic [15:0] roll;
    } result_t;

endpackage

FILE: sv/csq_cfg.sv
// Configuration register file of the compass I2C read sequencer.
// Depends on csq_pkg.
module csq_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [1:0]       wr_addr,
    input  logic [15:0]      wr_data,
    output csq_pkg::cfg_t    cfg
);

    csq_pkg::cfg_t cfg_reg;
    csq_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_addr)
                csq_pkg::CFG_SLAVE_ADDRESS: cfg_next.slave_address = wr_data[6:0];
                csq_pkg::CFG_COMMAND_BYTE:  cfg_next.command_byte  = wr_data[7:0];
                csq_pkg::CFG_SETTLE_TICKS:  cfg_next.settle_ticks  = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= csq_pkg::SLAVE_ADDRESS_RST;
            cfg_reg.command_byte  <= csq_pkg::COMMAND_BYTE_RST;
            cfg_reg.settle_ticks  <= csq_pkg::SETTLE_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/csq_fsm.sv
// Sequencing state machine: holds phase, byte index, settle counter and the
// measurement, and forms the result of one event. Depends on csq_pkg.
module csq_fsm #(
    parameter int READ_BYTES = csq_pkg::READ_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [1:0]        cmd,
    input  logic [7:0]        bus_status,
    input  logic [7:0]        rx_byte,
    input  csq_pkg::cfg_t     cfg,
    output csq_pkg::result_t  res
);

    localparam logic [csq_pkg::BYTE_IDX_W-1:0] LAST_IDX =
        csq_pkg::BYTE_IDX_W'(READ_BYTES - 1);
    localparam logic [csq_pkg::BYTE_IDX_W-1:0] TOP_BYTE = csq_pkg::BYTE_IDX_W'(5);

    csq_pkg::phase_t                   phase_reg, phase_next;
    logic [csq_pkg::BYTE_IDX_W-1:0]    idx_reg, idx_next;
    logic [15:0]                       wait_reg, wait_next;
    logic [csq_pkg::MEAS_W-1:0]        meas_reg, meas_next;
    logic [csq_pkg::MEAS_W-1:0]        meas_ins;
    logic [csq_pkg::BYTE_IDX_W-1:0]    byte_slot;
    logic [5:0]                        shamt;
    logic                              last;
    logic                              bad;

    // The first received byte lands in the top byte of the measurement.
    assign byte_slot = TOP_BYTE - idx_reg;
    assign shamt     = {byte_slot, 3'b000};
    assign meas_ins  = meas_reg | ({40'd0, rx_byte} << shamt);
    assign last      = (idx_reg == LAST_IDX);

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        meas_next  = meas_reg;
        res        = '0;
        bad        = 1'b0;
        case (cmd)
            csq_pkg::CMD_START: begin
                if (phase_reg == csq_pkg::PH_IDLE) begin
                    res.bus_action = csq_pkg::ACT_START;
                    phase_next     = csq_pkg::PH_START1;
                end
            end
            csq_pkg::CMD_TICK: begin
                if (phase_reg == csq_pkg::PH_SETTLE) begin
                    if (wait_reg <= 16'd1) begin
                        wait_next      = '0;
                        res.bus_action = csq_pkg::ACT_START;
                        phase_next     = csq_pkg::PH_START2;
                    end else begin
                        wait_next = wait_reg - 16'd1;
                    end
                end
            end
            csq_pkg::CMD_STATUS: begin
                unique case (phase_reg)
                    csq_pkg::PH_START1: begin
                        if (bus_status == csq_pkg::ST_START_DONE) begin
                            res.bus_action = csq_pkg::ACT_SEND;
                            res.tx_byte    = {cfg.slave_address, 1'b0};
                            phase_next     = csq_pkg::PH_ADDRW;
                        end
                    end
                    csq_pkg::PH_ADDRW: begin
                        if (bus_status == csq_pkg::ST_ADDRW_ACK) begin
                            res.bus_action = csq_pkg::ACT_SEND;
                            res.tx_byte    = cfg.command_byte;
                            phase_next     = csq_pkg::PH_CMD;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    csq_pkg::PH_CMD: begin
                        if (bus_status == csq_pkg::ST_DATA_ACK) begin
                            res.bus_action = csq_pkg::ACT_STOP;
                            wait_next      = cfg.settle_ticks;
                            phase_next     = csq_pkg::PH_SETTLE;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    csq_pkg::PH_START2: begin
                        if (bus_status == csq_pkg::ST_START_DONE) begin
                            res.bus_action = csq_pkg::ACT_SEND;
                            res.tx_byte    = {cfg.slave_address, 1'b1};
                            phase_next     = csq_pkg::PH_ADDRR;
                        end
                    end
                    csq_pkg::PH_ADDRR: begin
                        if (bus_status == csq_pkg::ST_ADDRR_ACK) begin
                            idx_next       = '0;
                            meas_next      = '0;
                            res.bus_action = csq_pkg::ACT_RX_ACK;
                            phase_next     = csq_pkg::PH_READ;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    csq_pkg::PH_READ: begin
                        if ((!last && bus_status == csq_pkg::ST_RX_ACK) ||
                            (last && bus_status == csq_pkg::ST_RX_NACK)) begin
                            meas_next = meas_ins;
                            if (last) begin
                                res.bus_action = csq_pkg::ACT_STOP;
                                res.done_res   = 1'b1;
                                res.heading    = meas_ins[47:32];
                                res.pitch      = meas_ins[31:16];
                                res.roll       = meas_ins[15:0];
                                phase_next     = csq_pkg::PH_IDLE;
                                idx_next       = '0;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                                // The byte after this one is the last when idx + 1 hits the end.
                                res.bus_action = (idx_reg + 1'b1 == LAST_IDX) ?
                                                 csq_pkg::ACT_RX_NACK : csq_pkg::ACT_RX_ACK;
                            end
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (bad) begin
                    res            = '0;
                    res.bus_action = csq_pkg::ACT_STOP;
                    res.failed     = 1'b1;
                    phase_next     = csq_pkg::PH_IDLE;
                    idx_next       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= csq_pkg::PH_IDLE;
            idx_reg   <= '0;
            wait_reg  <= '0;
            meas_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            wait_reg  <= wait_next;
            meas_reg  <= meas_next;
        end
    end

endmodule

FILE: sv/compass_i2c_read_sequencer.sv
// Top level of the compass I2C read sequencer: input register, state machine
// and result register. Depends on csq_pkg, csq_cfg and csq_fsm.
//
// Each accepted event (start, bus status or tick) yields exactly one result on
// the m_ channel. An event is held in the input register, the state machine
// evaluates it against the current phase, and the result register holds the
// outcome until it is taken; a new transfer is taken every cycle as long as
// the result side keeps up, so the block sustains one event per clock.
// Configuration writes are always accepted and registered, and should only
// be made while no measurement is in progress.
module compass_i2c_read_sequencer #(
    parameter int READ_BYTES = csq_pkg::READ_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_bus_status,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_bus_action,
    output logic [7:0]  m_tx_byte,
    output logic        m_done_res,
    output logic        m_failed,
    output logic [15:0] m_heading,
    output logic [15:0] m_pitch,
    output logic [15:0] m_roll,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    csq_pkg::cfg_t    cfg;
    csq_pkg::result_t res;
    csq_pkg::result_t res_reg;

    logic       in_vld_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_status_reg;
    logic [7:0] in_rx_reg;
    logic       out_vld_reg;
    logic       advance;

    // The held event moves on whenever the result register is free or being emptied.
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    csq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    csq_fsm #(
        .READ_BYTES (READ_BYTES)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .cmd        (in_cmd_reg),
        .bus_status (in_status_reg),
        .rx_byte    (in_rx_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg    <= s_cmd;
            in_status_reg <= s_bus_status;
            in_rx_reg     <= s_rx_byte;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_bus_action = res_reg.bus_action;
    assign m_tx_byte    = res_reg.tx_byte;
    assign m_done_res   = res_reg.done_res;
    assign m_failed     = res_reg.failed;
    assign m_heading    = res_reg.heading;
    assign m_pitch      = res_reg.pitch;
    assign m_roll       = res_reg.roll;

endmodule

FILE: sv/csq_checker.sv
// Port-level checks for the compass I2C read sequencer, bound to the top level.
// Depends on csq_pkg and compass_i2c_read_sequencer.
module csq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_bus_action,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_done_res,
    input  logic        m_failed,
    input  logic [15:0] m_heading,
    input  logic [15:0] m_pitch,
    input  logic [15:0] m_roll
);

    // A result that has not been transferred must still be offered next cycle.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transfer");

    // Completion and abort both close the bus with a STOP and never coincide.
    a_end_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_done_res || m_failed) |->
            (m_bus_action == csq_pkg::ACT_STOP) && !(m_done_res && m_failed))
        else $error("completion or abort without a lone STOP");

    // The measurement words are only shown with a completed measurement.
    a_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_heading == 16'd0 && m_pitch == 16'd0 && m_roll == 16'd0)
        else $error("measurement words shown without completion");

    // A transmit byte only travels with a send action.
    a_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_action != csq_pkg::ACT_SEND |-> m_tx_byte == 8'd0)
        else $error("transmit byte without send action");

endmodule

bind compass_i2c_read_sequencer csq_checker u_csq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_bus_action (m_bus_action),
    .m_tx_byte    (m_tx_byte),
    .m_done_res   (m_done_res),
    .m_failed     (m_failed),
    .m_heading    (m_heading),
    .m_pitch      (m_pitch),
    .m_roll       (m_roll)
);
